FILE: src/rmmb_pkg.sv
// rmmb_pkg: shared constants, codes and types of the region mapped memory bus
`timescale 1ns / 1ps
`default_nettype none

package rmmb_pkg;

    localparam int REGION_COUNT    = 4;
    localparam int STORE_ADDR_BITS = 16;
    localparam int CFG_INDEX_BITS  = 3;

    // configuration register indexes; windows use indexes 0 up to REGION_COUNT-1
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLAGS   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASES   = 3'd5;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [1:0] WIDTH_BYTE = 2'd0;
    localparam logic [1:0] WIDTH_HALF = 2'd1;
    localparam logic [1:0] WIDTH_WORD = 2'd2;

    localparam logic [31:0] FAIL_BYTE = 32'h0000_00FF;
    localparam logic [31:0] FAIL_HALF = 32'h0000_FFFF;
    localparam logic [31:0] FAIL_WORD = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_UNMAPPED   = 3'd1,
        ST_DENIED     = 3'd2,
        ST_MISALIGNED = 3'd3,
        ST_EXTERNAL   = 3'd4
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [1:0] hit;
        logic       go;
    } dec_t;

endpackage

`default_nettype wire

FILE: src/rmmb_ram.sv
// rmmb_ram: generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rmmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: src/rmmb_decode.sv
// rmmb_decode: alignment check, region lookup, permission check and store address
`timescale 1ns / 1ps
`default_nettype none

module rmmb_decode #(
    parameter int REGION_COUNT    = rmmb_pkg::REGION_COUNT,
    parameter int STORE_ADDR_BITS = rmmb_pkg::STORE_ADDR_BITS
) (
    input  logic                         kind,
    input  logic [1:0]                   access_width,
    input  logic [31:0]                  address,
    input  logic [63:0]                  windows [REGION_COUNT],
    input  logic [3*REGION_COUNT-1:0]    flags,
    input  logic [16*REGION_COUNT-1:0]   bases,
    output rmmb_pkg::dec_t               dec,
    output logic [STORE_ADDR_BITS-1:0]   store_addr
);

    logic [32:0]             diff [REGION_COUNT];
    logic [REGION_COUNT-1:0] hits;

    // offset into each window; a borrow means the address lies below the start
    always_comb
    begin
        for (int k = 0; k < REGION_COUNT; k++)
        begin
            diff[k] = {1'b0, address} - {1'b0, windows[k][31:0]};
            hits[k] = (windows[k][63:32] != 32'd0) && !diff[k][32]
                      && (diff[k][31:0] < windows[k][63:32]);
        end
    end

    always_comb
    begin
        logic        found;
        logic        misaligned;
        logic        allowed;
        logic [1:0]  sel_k;
        logic [2:0]  sel_fl;
        logic [15:0] sel_base;
        logic [31:0] sel_off;
        logic [31:0] sum;

        found    = 1'b0;
        sel_k    = 2'd0;
        sel_fl   = 3'd0;
        sel_base = 16'd0;
        sel_off  = 32'd0;
        for (int k = 0; k < REGION_COUNT; k++)
        begin
            if (!found && hits[k])
            begin
                found    = 1'b1;
                sel_k    = 2'(k);
                sel_fl   = flags[3*k +: 3];
                sel_base = bases[16*k +: 16];
                sel_off  = diff[k][31:0];
            end
        end

        case (access_width)
            rmmb_pkg::WIDTH_BYTE: misaligned = 1'b0;
            rmmb_pkg::WIDTH_HALF: misaligned = address[0];
            rmmb_pkg::WIDTH_WORD: misaligned = (address[1:0] != 2'd0);
            default:              misaligned = 1'b1;
        endcase

        allowed = (kind == rmmb_pkg::KIND_WRITE) ? sel_fl[1] : sel_fl[0];

        dec.go  = 1'b0;
        dec.hit = sel_k;
        if (misaligned)
        begin
            dec.status = rmmb_pkg::ST_MISALIGNED;
            dec.hit    = 2'd0;
        end
        else if (!found)
        begin
            dec.status = rmmb_pkg::ST_UNMAPPED;
        end
        else if (!allowed)
        begin
            dec.status = rmmb_pkg::ST_DENIED;
        end
        else if (sel_fl[2])
        begin
            dec.status = rmmb_pkg::ST_EXTERNAL;
        end
        else
        begin
            dec.status = rmmb_pkg::ST_DONE;
            dec.go     = 1'b1;
        end

        // store address wraps modulo the store size
        sum        = {16'd0, sel_base} + sel_off;
        store_addr = sum[STORE_ADDR_BITS-1:0];
    end

endmodule

`default_nettype wire

FILE: src/region_mapped_memory_bus.sv
// region_mapped_memory_bus: top level, config registers, access sequencer and byte store
`timescale 1ns / 1ps
`default_nettype none
// sequence: DECODE, then when the store is accessed one ACCESS step per byte (one
// byte-wide ram port, one byte per cycle), then for a read a TAIL step for the registered
// ram read data; done rises as the sequence ends; the next start is taken in the done cycle
// a new transaction is taken only while idle; done is a one-cycle strobe
// reset: config registers clear, then a clearing pass zeroes every store byte in turn
// with busy high; config writes are taken throughout

module region_mapped_memory_bus #(
    parameter int REGION_COUNT    = rmmb_pkg::REGION_COUNT,
    parameter int STORE_ADDR_BITS = rmmb_pkg::STORE_ADDR_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               kind,
    input  logic [1:0]                         access_width,
    input  logic [31:0]                        address,
    input  logic [31:0]                        write_data,
    output logic                               done,
    output logic [31:0]                        read_data,
    output logic [2:0]                         status,
    output logic [1:0]                         region_hit,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rmmb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [63:0]                        cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DECODE = 5'b00100,
        S_ACCESS = 5'b01000,
        S_TAIL   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0]                 window_reg [REGION_COUNT];
    logic [3*REGION_COUNT-1:0]   flags_reg;
    logic [16*REGION_COUNT-1:0]  bases_reg;

    logic [STORE_ADDR_BITS-1:0]  clr_addr_reg;
    logic                        done_reg;

    logic                        kind_reg;
    logic [1:0]                  width_reg;
    logic [31:0]                 addr_reg;
    logic [31:0]                 wdata_reg;
    logic [STORE_ADDR_BITS-1:0]  mem_addr_reg;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  last_reg;
    logic [31:0]                 data_reg;
    logic [31:0]                 read_data_reg;
    logic [2:0]                  status_reg;
    logic [1:0]                  hit_reg;

    rmmb_pkg::dec_t              dec;
    logic [STORE_ADDR_BITS-1:0]  dec_addr;

    logic                        ram_we;
    logic [STORE_ADDR_BITS-1:0]  ram_addr;
    logic [7:0]                  ram_wdata;
    logic [7:0]                  ram_rdata;

    logic                        accept;
    logic [31:0]                 fail_value;
    logic [31:0]                 wdata_aligned;
    logic [1:0]                  last_idx;

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign read_data  = read_data_reg;
    assign status     = status_reg;
    assign region_hit = hit_reg;

    rmmb_decode #(
        .REGION_COUNT    (REGION_COUNT),
        .STORE_ADDR_BITS (STORE_ADDR_BITS)
    ) u_decode (
        .kind         (kind_reg),
        .access_width (width_reg),
        .address      (addr_reg),
        .windows      (window_reg),
        .flags        (flags_reg),
        .bases        (bases_reg),
        .dec          (dec),
        .store_addr   (dec_addr)
    );

    rmmb_ram #(
        .WIDTH (8),
        .DEPTH (2**STORE_ADDR_BITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = (state_reg == S_CLEAR)
                    || (state_reg == S_ACCESS && kind_reg == rmmb_pkg::KIND_WRITE);
        ram_addr  = (state_reg == S_CLEAR) ? clr_addr_reg : mem_addr_reg;
        ram_wdata = (state_reg == S_CLEAR) ? 8'd0 : data_reg[31:24];
    end

    // write bytes leave from the top of data_reg, most significant first
    always_comb
    begin
        case (width_reg)
            rmmb_pkg::WIDTH_BYTE:
            begin
                fail_value    = rmmb_pkg::FAIL_BYTE;
                wdata_aligned = {wdata_reg[7:0], 24'd0};
                last_idx      = 2'd0;
            end
            rmmb_pkg::WIDTH_HALF:
            begin
                fail_value    = rmmb_pkg::FAIL_HALF;
                wdata_aligned = {wdata_reg[15:0], 16'd0};
                last_idx      = 2'd1;
            end
            default:
            begin
                fail_value    = rmmb_pkg::FAIL_WORD;
                wdata_aligned = wdata_reg;
                last_idx      = 2'd3;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == {STORE_ADDR_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = dec.go ? S_ACCESS : S_IDLE;
            end
            S_ACCESS:
            begin
                if (cnt_reg == last_reg)
                begin
                    state_next = (kind_reg == rmmb_pkg::KIND_WRITE) ? S_IDLE : S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            done_reg <= (state_reg == S_DECODE && !dec.go)
                        || (state_reg == S_ACCESS && cnt_reg == last_reg
                            && kind_reg == rmmb_pkg::KIND_WRITE)
                        || (state_reg == S_TAIL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < REGION_COUNT; k++)
            begin
                window_reg[k] <= 64'd0;
            end
            flags_reg <= '0;
            bases_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int k = 0; k < REGION_COUNT; k++)
            begin
                if (cfg_index == rmmb_pkg::CFG_WINDOW0 + 3'(k))
                begin
                    window_reg[k] <= cfg_data;
                end
            end
            if (cfg_index == rmmb_pkg::CFG_FLAGS)
            begin
                flags_reg <= cfg_data[3*REGION_COUNT-1:0];
            end
            if (cfg_index == rmmb_pkg::CFG_BASES)
            begin
                bases_reg <= cfg_data[16*REGION_COUNT-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_reg  <= kind;
                    width_reg <= access_width;
                    addr_reg  <= address;
                    wdata_reg <= write_data;
                end
            end
            S_DECODE:
            begin
                status_reg   <= dec.status;
                hit_reg      <= dec.hit;
                mem_addr_reg <= dec_addr;
                cnt_reg      <= 2'd0;
                last_reg     <= last_idx;
                data_reg     <= (kind_reg == rmmb_pkg::KIND_WRITE) ? wdata_aligned : 32'd0;
                if (kind_reg == rmmb_pkg::KIND_WRITE || dec.status == rmmb_pkg::ST_EXTERNAL)
                begin
                    read_data_reg <= 32'd0;
                end
                else
                begin
                    read_data_reg <= fail_value;
                end
            end
            S_ACCESS:
            begin
                mem_addr_reg <= mem_addr_reg + 1'b1;
                cnt_reg      <= cnt_reg + 2'd1;
                if (kind_reg == rmmb_pkg::KIND_WRITE)
                begin
                    data_reg      <= {data_reg[23:0], 8'd0};
                    read_data_reg <= 32'd0;
                end
                else if (cnt_reg != 2'd0)
                begin
                    // ram data of the byte issued last cycle
                    data_reg <= {data_reg[23:0], ram_rdata};
                end
            end
            S_TAIL:
            begin
                read_data_reg <= {data_reg[23:0], ram_rdata};
            end
            default:
            begin
                data_reg <= data_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/rmmb_checker.sv
// rmmb_checker: port-level assertions on the region mapped memory bus, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rmmb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] read_data,
    input logic [2:0]  status,
    input logic [1:0]  region_hit
);

    // one transaction yields a single one-cycle strobe
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe lasted more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    a_misaligned_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == rmmb_pkg::ST_MISALIGNED) |-> (region_hit == 2'd0))
        else $error("misaligned access reported a region");

    a_external_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == rmmb_pkg::ST_EXTERNAL) |-> (read_data == 32'd0))
        else $error("external region returned nonzero data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= 3'd4))
        else $error("status code out of range");

endmodule

bind region_mapped_memory_bus rmmb_checker u_rmmb_checker (.*);

`default_nettype wire

FILE: bench/region_mapped_memory_bus_tb.sv
// region_mapped_memory_bus_tb: self-checking testbench with a bus access predictor
`timescale 1ns / 1ps

module region_mapped_memory_bus_tb;

    import rmmb_pkg::*;

    localparam logic [1:0] WIDTH_BAD = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;
    localparam int STORE_BYTES = 1 << STORE_ADDR_BITS;

    localparam logic [2:0] FL_RD  = 3'b001;
    localparam logic [2:0] FL_WR  = 3'b010;
    localparam logic [2:0] FL_EXT = 3'b100;

    typedef enum int { MODE_TYPICAL, MODE_ALL_ONES, MODE_ALL_ZERO } setting_mode_t;

    typedef struct packed {
        logic [31:0] data;
        status_t     st;
        logic [1:0]  hit;
    } access_result_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic                      kind         = KIND_READ;
    logic [1:0]                access_width = WIDTH_BYTE;
    logic [31:0]               address      = '0;
    logic [31:0]               write_data   = '0;
    logic                      cfg_valid    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [63:0]               cfg_data     = '0;
    logic                      busy;
    logic                      done;
    logic [31:0]               read_data;
    logic [2:0]                status;
    logic [1:0]                region_hit;
    logic                      cfg_ready;

    // shadow of the register file and the byte store
    logic [63:0] window_regs [REGION_COUNT];
    logic [11:0] flag_bits   = '0;
    logic [63:0] base_bits   = '0;
    logic [7:0]  store_image [STORE_BYTES];

    access_result_t pending_results[$];
    int errors = 0;
    int accesses = 0;
    int settings = 0;
    int outcome_count [5];
    bit start_held = 1'b0;
    bit steady = 1'b0;
    int pending_gap = 0;
    int burst_left = 0;

    region_mapped_memory_bus u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .access_width (access_width),
        .address      (address),
        .write_data   (write_data),
        .done         (done),
        .read_data    (read_data),
        .status       (status),
        .region_hit   (region_hit),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] window(input logic [31:0] base_addr, input logic [31:0] size);
        return {size, base_addr};
    endfunction

    // decode, permission check and store access of one bus transaction
    function automatic access_result_t bus_access(input logic wr, input logic [1:0] w,
            input logic [31:0] addr, input logic [31:0] wd);
        access_result_t r;
        int nbytes;
        int region;
        int k;
        int i;
        logic [31:0] fail_val;
        logic [31:0] win_lo;
        logic [32:0] win_end;
        logic [31:0] offs;
        logic [2:0] fl;
        logic [15:0] slot;
        r.data = '0;
        r.st = ST_DONE;
        r.hit = '0;
        region = -1;
        nbytes = (w == WIDTH_BYTE) ? 1 : (w == WIDTH_HALF) ? 2 : 4;
        fail_val = (w == WIDTH_BYTE) ? FAIL_BYTE : (w == WIDTH_HALF) ? FAIL_HALF : FAIL_WORD;
        if (w == WIDTH_BAD || (addr & 32'(nbytes - 1)) != 0)
            r.st = ST_MISALIGNED;
        else
        begin
            // walk downward so the lowest matching region wins
            for (k = REGION_COUNT - 1; k >= 0; k--)
            begin
                win_lo = window_regs[k][31:0];
                win_end = {1'b0, win_lo} + {1'b0, window_regs[k][63:32]};
                if (window_regs[k][63:32] != 0 && addr >= win_lo && {1'b0, addr} < win_end)
                    region = k;
            end
            if (region < 0)
                r.st = ST_UNMAPPED;
            else
            begin
                r.hit = 2'(region);
                fl = flag_bits[3*region +: 3];
                if ((wr == KIND_WRITE) ? !fl[1] : !fl[0])
                    r.st = ST_DENIED;
                else if (fl[2])
                    r.st = ST_EXTERNAL;
                else
                begin
                    offs = addr - window_regs[region][31:0];
                    for (i = 0; i < nbytes; i++)
                    begin
                        slot = base_bits[16*region +: 16] + offs[15:0] + 16'(i);
                        if (wr == KIND_WRITE)
                            store_image[slot] = 8'(wd >> (8 * (nbytes - 1 - i)));
                        else
                            r.data = {r.data[23:0], store_image[slot]};
                    end
                end
            end
        end
        if (wr == KIND_WRITE || r.st == ST_EXTERNAL)
            r.data = '0;
        else if (r.st != ST_DONE)
            r.data = fail_val;
        return r;
    endfunction

    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, actual data %h status %0d hit %0d",
                         $time, read_data, status, region_hit);
            end
            else
            begin
                want = pending_results.pop_front();
                outcome_count[want.st]++;
                if (read_data !== want.data)
                begin
                    errors++;
                    $display("%0t: read_data expected %h actual %h", $time, want.data, read_data);
                end
                if (status !== want.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                end
                if (region_hit !== want.hit)
                begin
                    errors++;
                    $display("%0t: region_hit expected %0d actual %0d", $time, want.hit, region_hit);
                end
            end
        end
    end

    task automatic send_access(input logic wr, input logic [1:0] w, input logic [31:0] addr,
            input logic [31:0] wd);
        repeat (pending_gap) @(posedge clk);
        start <= 1'b1;
        kind <= wr;
        access_width <= w;
        address <= addr;
        write_data <= wd;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(bus_access(wr, w, addr, wd));
        accesses++;
        if (steady)
            pending_gap = 0;
        else if (burst_left > 0)
        begin
            burst_left--;
            pending_gap = 0;
        end
        else
        begin
            burst_left = $urandom_range(0, 24);
            pending_gap = $urandom_range(1, 9);
        end
        // keep start high only when the next transaction follows at once
        start_held = (pending_gap == 0);
        if (!start_held)
            start <= 1'b0;
    endtask

    task automatic wait_quiet(input int settle);
        if (start_held)
            start <= 1'b0;
        start_held = 1'b0;
        pending_gap = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < REGION_COUNT)
            window_regs[idx] = value;
        else if (idx == CFG_FLAGS)
            flag_bits = value[11:0];
        else if (idx == CFG_BASES)
            base_bits = value;
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic configure(input setting_mode_t mode);
        logic [31:0] lo;
        logic [31:0] size;
        logic [31:0] prev_lo;
        logic [11:0] fl;
        logic [63:0] bases;
        int k;
        int pick;
        prev_lo = $urandom;
        fl = '0;
        bases = '0;
        for (k = 0; k < REGION_COUNT; k++)
        begin
            pick = $urandom_range(0, 9);
            lo = $urandom;
            size = $urandom_range(1, 300);
            if (mode == MODE_ALL_ONES)
            begin
                lo = '1;
                size = '1;
            end
            else if (mode == MODE_ALL_ZERO)
            begin
                lo = '0;
                size = '0;
            end
            else if (pick == 0)
                size = '0;
            else if (pick == 1)
            begin
                lo = '0;
                size = '1;
            end
            else if (pick == 2)
                lo = 32'hFFFF_FFFF - $urandom_range(0, 255);
            else if (pick == 3)
                lo = prev_lo + $urandom_range(0, 64);
            prev_lo = lo;
            cfg_write(CFG_INDEX_BITS'(k), window(lo, size));
            fl[3*k +: 3] = {$urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0,
                            $urandom_range(0, 4) != 0};
            pick = $urandom_range(0, 5);
            bases[16*k +: 16] = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom);
        end
        if (mode == MODE_ALL_ONES)
        begin
            cfg_write(CFG_FLAGS, '1);
            cfg_write(CFG_BASES, '1);
            cfg_write(CFG_SPARE_LO, '0);
        end
        else if (mode == MODE_ALL_ZERO)
        begin
            cfg_write(CFG_FLAGS, '0);
            cfg_write(CFG_BASES, '0);
            cfg_write(CFG_SPARE_HI, '1);
        end
        else
        begin
            // junk above bit 11 of the flags must be dropped
            cfg_write(CFG_FLAGS, {$urandom, 20'($urandom), fl});
            cfg_write(CFG_BASES, bases);
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, $urandom});
        end
        cfg_release();
    endtask

    function automatic logic [31:0] pick_address(input logic [1:0] w);
        logic [31:0] addr;
        logic [31:0] size;
        int k;
        int pick;
        pick = $urandom_range(0, 9);
        k = $urandom_range(0, REGION_COUNT - 1);
        size = window_regs[k][63:32];
        if (pick < 8)
            addr = window_regs[k][31:0] + ((size == 0) ? 32'd0 : $urandom % size);
        else
            addr = $urandom;
        if ($urandom_range(0, 7) != 0)
            addr = addr & ~32'((w == WIDTH_BYTE) ? 0 : (w == WIDTH_HALF) ? 1 : 3);
        return addr;
    endfunction

    task automatic run_traffic(input int count);
        logic wr;
        logic [1:0] w;
        logic [31:0] addr;
        logic last_wr;
        logic [1:0] last_w;
        logic [31:0] last_addr;
        int n;
        last_wr = KIND_READ;
        last_w = WIDTH_BYTE;
        last_addr = '0;
        for (n = 0; n < count; n++)
        begin
            if (last_wr == KIND_WRITE && $urandom_range(0, 2) == 0)
            begin
                // read back what was just written
                wr = KIND_READ;
                w = last_w;
                addr = last_addr;
            end
            else
            begin
                wr = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
                w = ($urandom_range(0, 15) == 0) ? WIDTH_BAD : 2'($urandom_range(0, 2));
                addr = pick_address(w);
            end
            send_access(wr, w, addr, $urandom);
            last_wr = wr;
            last_w = w;
            last_addr = addr;
        end
    endtask

    task automatic test_reset_defaults();
        // every region is disabled until written, the clearing pass holds these off
        send_access(KIND_READ, WIDTH_WORD, 32'h0000_0000, 32'h0);
        send_access(KIND_WRITE, WIDTH_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(KIND_READ, WIDTH_HALF, 32'h8000_0001, 32'h0);
        wait_quiet(4);
    endtask

    task automatic test_directed_map();
        cfg_write(CFG_WINDOW0, window(32'h0000_1000, 32'h102));
        cfg_write(CFG_INDEX_BITS'(1), window(32'h0000_1080, 32'h100));
        cfg_write(CFG_INDEX_BITS'(2), window(32'hFFFF_FF00, 32'h100));
        cfg_write(CFG_INDEX_BITS'(3), window(32'h0000_2000, 32'h10));
        cfg_write(CFG_FLAGS, {52'h0, FL_RD | FL_WR | FL_EXT, FL_RD | FL_WR, FL_RD, FL_RD | FL_WR});
        cfg_write(CFG_BASES, {16'h0000, 16'hFFF2, 16'h4000, 16'h0000});
        cfg_release();
        send_access(KIND_WRITE, WIDTH_WORD, 32'h0000_1000, 32'hFFFF_FFFF);
        send_access(KIND_WRITE, WIDTH_HALF, 32'h0000_1002, 32'h0000_A55A);
        send_access(KIND_WRITE, WIDTH_BYTE, 32'h0000_1001, 32'h0000_0000);
        send_access(KIND_READ, WIDTH_WORD, 32'h0000_1000, 32'h0);
        // word starting on the last byte pair of region 0 runs past its end
        send_access(KIND_WRITE, WIDTH_WORD, 32'h0000_1100, 32'h1234_5678);
        send_access(KIND_READ, WIDTH_WORD, 32'h0000_1100, 32'h0);
        send_access(KIND_READ, WIDTH_HALF, 32'h0000_1101, 32'h0);
        send_access(KIND_WRITE, WIDTH_BAD, 32'h0000_1000, 32'hFFFF_FFFF);
        send_access(KIND_READ, WIDTH_BAD, 32'h0000_1000, 32'h0);
        // store offset wraps from the top of the store back to zero
        send_access(KIND_WRITE, WIDTH_WORD, 32'hFFFF_FF0C, 32'hCAFE_F00D);
        send_access(KIND_READ, WIDTH_WORD, 32'h0000_1000, 32'h0);
        send_access(KIND_READ, WIDTH_BYTE, 32'hFFFF_FFFF, 32'h0);
        send_access(KIND_WRITE, WIDTH_HALF, 32'h0000_1102, 32'h0000_FFFF);
        send_access(KIND_READ, WIDTH_WORD, 32'h0000_1080, 32'h0);
        send_access(KIND_WRITE, WIDTH_WORD, 32'h0000_2000, 32'h8000_0001);
        send_access(KIND_READ, WIDTH_BYTE, 32'h0000_200F, 32'h0);
        send_access(KIND_READ, WIDTH_BYTE, 32'h0000_2010, 32'h0);
        wait_quiet(4);
    endtask

    task automatic test_permission_order();
        cfg_write(CFG_FLAGS, {52'h0, FL_WR | FL_EXT, FL_EXT, FL_WR, FL_WR});
        cfg_release();
        send_access(KIND_READ, WIDTH_WORD, 32'h0000_1000, 32'h0);
        send_access(KIND_WRITE, WIDTH_BYTE, 32'h0000_1001, 32'h0000_00C3);
        send_access(KIND_READ, WIDTH_HALF, 32'h0000_1102, 32'h0);
        send_access(KIND_WRITE, WIDTH_WORD, 32'hFFFF_FF00, 32'h0);
        // permission is checked before the external flag
        send_access(KIND_READ, WIDTH_BYTE, 32'h0000_2001, 32'h0);
        send_access(KIND_WRITE, WIDTH_BYTE, 32'h0000_2001, 32'h0000_0055);
        wait_quiet(4);
        cfg_write(CFG_WINDOW0, window(32'h0000_1000, 32'h0));
        cfg_release();
        send_access(KIND_READ, WIDTH_BYTE, 32'h0000_1000, 32'h0);
        wait_quiet(4);
    endtask

    task automatic test_register_extremes();
        configure(MODE_ALL_ONES);
        run_traffic(60);
        wait_quiet(4);
        configure(MODE_ALL_ZERO);
        run_traffic(60);
        wait_quiet(4);
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 5; phase++)
        begin
            steady = (phase % 3 == 1);
            configure(MODE_TYPICAL);
            run_traffic(350);
            wait_quiet(4);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        foreach (store_image[i])
            store_image[i] = '0;
        foreach (window_regs[i])
            window_regs[i] = '0;
        foreach (outcome_count[i])
            outcome_count[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_map();
        test_permission_order();
        test_register_extremes();
        test_random_traffic();
        wait_quiet(8);
        $display("covered %0d accesses under %0d register settings", accesses, settings);
        $display("outcomes: done %0d, unmapped %0d, denied %0d, misaligned %0d, external %0d",
                 outcome_count[ST_DONE], outcome_count[ST_UNMAPPED], outcome_count[ST_DENIED],
                 outcome_count[ST_MISALIGNED], outcome_count[ST_EXTERNAL]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
